### rtl/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg - shared types and constants of the sextant cell reducer
// Dot encoding, result bundle and stream widths used by every module.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int COLOUR_BITS = 8;
  localparam int CELL_DOTS   = 6;
  localparam int CNT_W       = $clog2(CELL_DOTS + 1);

  localparam int COORD_W     = 8;
  localparam int DOT_FIELD_W = 9;
  localparam int COLOUR_W    = 8;
  localparam int GLYPH_W     = CELL_DOTS;

  localparam int DOTS_LSB    = 2 * COORD_W;
  localparam int IN_FIELDS_W = DOTS_LSB + CELL_DOTS * DOT_FIELD_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * COORD_W + 2 * COLOUR_W + GLYPH_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [COLOUR_BITS-1:0] colour_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // One dot after decode: any negative field value counts as unset.
  typedef struct packed {
    logic    unset;
    colour_t colour;
  } dot_t;

  typedef dot_t [CELL_DOTS-1:0] cell_dots_t;

  // Reduction result handed from the reducer to the result register.
  typedef struct packed {
    logic                has_ink;
    colour_t             fg;
    colour_t             bg;
    logic [GLYPH_W-1:0]  glyph;
  } reduce_res_t;

  function automatic dot_t dot_decode(input logic [DOT_FIELD_W-1:0] raw);
    dot_t d;
    d.unset  = raw[DOT_FIELD_W-1];
    d.colour = raw[COLOUR_BITS-1:0];
    return d;
  endfunction

  // Two unset dots match each other; a set dot matches on colour only.
  function automatic logic dot_eq(input dot_t a, input dot_t b);
    return (a.unset && b.unset) || (!a.unset && !b.unset && (a.colour == b.colour));
  endfunction

endpackage

### rtl/scr_reduce.sv
// ----------------------------------------------------------------------------
// scr_reduce - two-colour reduction of one sextant cell
// Counts matches per dot, picks ink and paper, builds the glyph mask.
// ----------------------------------------------------------------------------
module scr_reduce
  import scr_pkg::*;
(
  input  cell_dots_t         dots,
  input  logic [COLOUR_W-1:0] empty_colour,
  output reduce_res_t        res
);

  cnt_t cnt [CELL_DOTS];

  // Occurrence count of each dot's value within the cell.
  always_comb begin
    for (int k = 0; k < CELL_DOTS; k++) begin
      cnt[k] = '0;
      for (int m = 0; m < CELL_DOTS; m++) begin
        cnt[k] = cnt[k] + cnt_t'(dot_eq(dots[m], dots[k]));
      end
    end
  end

  logic    ink_found;
  cnt_t    ink_cnt;
  colour_t ink_col;
  dot_t    ink_dot;
  logic    pap_found;
  cnt_t    pap_cnt;
  dot_t    pap_dot;

  always_comb begin
    ink_found = 1'b0;
    ink_cnt   = '0;
    ink_col   = '0;
    // Ink: highest count among set dots, larger colour wins a tie.
    for (int k = 0; k < CELL_DOTS; k++) begin
      if (!dots[k].unset &&
          (!ink_found || (cnt[k] > ink_cnt) ||
           ((cnt[k] == ink_cnt) && (dots[k].colour > ink_col)))) begin
        ink_found = 1'b1;
        ink_cnt   = cnt[k];
        ink_col   = dots[k].colour;
      end
    end
    ink_dot.unset  = 1'b0;
    ink_dot.colour = ink_col;

    // Paper: first dot off the ink with the strictly highest count.
    pap_found = 1'b0;
    pap_cnt   = '0;
    pap_dot   = '0;
    for (int k = 0; k < CELL_DOTS; k++) begin
      if (!dot_eq(dots[k], ink_dot) && (!pap_found || (cnt[k] > pap_cnt))) begin
        pap_found = 1'b1;
        pap_cnt   = cnt[k];
        pap_dot   = dots[k];
      end
    end

    res.has_ink = ink_found;
    res.fg      = ink_col;
    res.bg      = (pap_found && !pap_dot.unset) ? pap_dot.colour
                                                : empty_colour[COLOUR_BITS-1:0];
    for (int k = 0; k < CELL_DOTS; k++) begin
      res.glyph[k] = dot_eq(dots[k], ink_dot);
    end
  end

endmodule

### rtl/sextant_cell_two_colour_reducer.sv
// ----------------------------------------------------------------------------
// sextant_cell_two_colour_reducer - sextant cell to two-colour glyph
// Input register, one reduction stage, result register on a stream bus.
// ----------------------------------------------------------------------------
// The block takes one cell per clock unless the result side stalls: the input
// beat lands in the input register, the reduction runs in one stage of
// compares and small counts, and the result register holds the glyph beat
// until the sink takes it. Throughput is one cell per cycle, set by that
// single reduction stage; a stalled result register holds the
// input register, and in_tready drops only while both are full and out_tready
// is low. A cell whose six dots are all unset (any negative dot value) gives
// no output beat. The ink is the most common set colour, larger colour on a
// tie; the paper is the first dot, in index order, that differs from the ink
// with the highest count; an unset or absent paper takes the empty colour
// register. Write that register with cfg_wr_en only while no cell is in
// flight; it resets to 0.
// ----------------------------------------------------------------------------
module sextant_cell_two_colour_reducer
  import scr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] cell_col, [15:8] cell_row, then 9 bits each from bit 16 up:
  // dot_r0_left, dot_r0_right, dot_r1_left, dot_r1_right, dot_r2_left,
  // dot_r2_right; [71:70] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,

  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] out_col, [15:8] out_row, [23:16] fg_colour, [31:24] bg_colour,
  // [37:32] glyph_bits, [39:38] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,

  input  logic                   cfg_wr_en,
  input  logic [COLOUR_W-1:0]    cfg_wr_data
);

  // Empty paper colour register.
  logic [COLOUR_W-1:0] empty_r, empty_nxt;

  // Input register.
  logic                s1_valid_r, s1_valid_nxt;
  logic [COORD_W-1:0]  s1_col_r, s1_col_nxt;
  logic [COORD_W-1:0]  s1_row_r, s1_row_nxt;
  cell_dots_t          s1_dots_r, s1_dots_nxt;

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic        out_free;
  logic        in_beat;
  reduce_res_t res;

  // The result register can load when empty or being drained this cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    empty_nxt = cfg_wr_en ? cfg_wr_data : empty_r;
  end

  // Capture the beat and decode its dots.
  always_comb begin
    s1_valid_nxt = in_tready ? in_tvalid : s1_valid_r;
    s1_col_nxt   = s1_col_r;
    s1_row_nxt   = s1_row_r;
    s1_dots_nxt  = s1_dots_r;
    if (in_beat) begin
      s1_col_nxt = in_tdata[COORD_W-1:0];
      s1_row_nxt = in_tdata[2*COORD_W-1:COORD_W];
      for (int k = 0; k < CELL_DOTS; k++) begin
        s1_dots_nxt[k] = dot_decode(in_tdata[DOTS_LSB + k*DOT_FIELD_W +: DOT_FIELD_W]);
      end
    end
  end

  scr_reduce u_reduce (
    .dots         (s1_dots_r),
    .empty_colour (empty_r),
    .res          (res)
  );

  // Advance into the result register; drop cells with no set dot.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_free) begin
      out_valid_nxt = s1_valid_r && res.has_ink;
      if (s1_valid_r && res.has_ink) begin
        out_data_nxt = OUT_TDATA_W'({res.glyph, COLOUR_W'(res.bg), COLOUR_W'(res.fg),
                                     s1_row_r, s1_col_r});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      empty_r     <= empty_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r   <= s1_col_nxt;
    s1_row_r   <= s1_row_nxt;
    s1_dots_r  <= s1_dots_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // A delivered glyph always marks at least the ink dot.
  a_glyph_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2*COORD_W+2*COLOUR_W +: GLYPH_W] != '0))
    else $error("glyph mask empty on an output beat");

  // A held input register keeps its cell while the result side stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_dots_r)))
    else $error("input register lost a stalled cell");

  // An empty input register always takes a beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input not ready with an empty input register");

  // A result appears only from a cell held in the input register.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("output beat without a source cell");
`endif

endmodule

### tb/sextant_cell_two_colour_reducer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sextant_cell_two_colour_reducer_test - self-checking bench for the reducer
// Streams six-dot cells into the block and predicts every glyph beat in the
// bench. Each glyph beat is compared field by field with the oldest
// prediction. Both stream sides idle at random. The sink holds off once so
// that the block stalls its input. The empty paper colour is rewritten
// between phases, only while no cell is in flight.
// ----------------------------------------------------------------------------
module sextant_cell_two_colour_reducer_test;
  import scr_pkg::*;

  localparam int IDLE_PCT      = 31;    // chance in a hundred that a side idles
  localparam int QUIET_LIMIT   = 1000;  // cycles with no beat before giving up
  localparam int SETTLE_CYCLES = 4;     // time for both pipeline registers to empty, plus margin
  localparam int HOLD_AFTER    = 200;   // glyph beats seen before the long hold-off
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASE_CELLS   = 420;

  localparam logic [DOT_FIELD_W-1:0] UNSET = '1;  // -1

  // One input beat, split into fields.
  typedef struct packed {
    logic [CELL_DOTS-1:0][DOT_FIELD_W-1:0] dots;  // dot k = 2*row + column
    logic [COORD_W-1:0]                    row;
    logic [COORD_W-1:0]                    col;
  } cell_t;

  // One glyph beat, split into fields.
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    colour_t            fg;
    colour_t            bg;
    logic [GLYPH_W-1:0] glyph;
  } glyph_beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [COLOUR_W-1:0]    cfg_wr_data = '0;

  cell_t       pending_cells[$];     // cells waiting for the driver
  glyph_beat_t expected_glyphs[$];   // predicted glyph beats, oldest first
  cell_t       held_cell;            // cell currently offered on in_*
  colour_t     empty_fill = '0;      // bench copy of the empty paper register
  bit          no_gaps = 1'b0;       // both sides run without idling
  bit          offering;
  glyph_beat_t predicted;

  int mismatches = 0;
  int cells_sent = 0;
  int cells_dropped = 0;
  int glyphs_checked = 0;
  int fill_settings = 0;
  int quiet_cycles = 0;
  int sink_hold_left = 0;
  bit sink_hold_done = 1'b0;

  sextant_cell_two_colour_reducer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // [7:0] cell_col, [15:8] cell_row, [24:16] dot_r0_left ... [69:61] dot_r2_right
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // [7:0] out_col, [15:8] out_row, [23:16] fg, [31:24] bg, [37:32] glyph
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Glyph predictor
  // --------------------------------------------------------------------------

  // Any dot with the sign bit set is unset; unset dots match each other.
  function automatic bit same_dot(input cell_t c, input int a, input int b);
    logic ua, ub;
    ua = c.dots[a][DOT_FIELD_W-1];
    ub = c.dots[b][DOT_FIELD_W-1];
    if (ua || ub)
      return ua && ub;
    return c.dots[a][COLOUR_BITS-1:0] == c.dots[b][COLOUR_BITS-1:0];
  endfunction

  // Reduce one cell; return 0 when no dot is set and the cell makes no glyph.
  function automatic bit reduce_cell(input cell_t c, input colour_t fill,
                                     output glyph_beat_t g);
    int      tally[CELL_DOTS];
    int      ink;
    int      paper;
    colour_t hue[CELL_DOTS];
    g = '0;
    for (int k = 0; k < CELL_DOTS; k++) begin
      hue[k] = c.dots[k][COLOUR_BITS-1:0];
      tally[k] = 0;
      for (int m = 0; m < CELL_DOTS; m++)
        if (same_dot(c, k, m))
          tally[k]++;
    end
    // Ink: the most frequent set colour, larger colour on a tie.
    ink = -1;
    for (int k = 0; k < CELL_DOTS; k++) begin
      if (c.dots[k][DOT_FIELD_W-1])
        continue;
      if (ink < 0 || tally[k] > tally[ink] ||
          (tally[k] == tally[ink] && hue[k] > hue[ink]))
        ink = k;
    end
    if (ink < 0)
      return 1'b0;
    // Paper: first dot off the ink with the highest count; may be unset.
    paper = -1;
    for (int k = 0; k < CELL_DOTS; k++) begin
      if (same_dot(c, k, ink))
        continue;
      if (paper < 0 || tally[k] > tally[paper])
        paper = k;
    end
    g.col = c.col;
    g.row = c.row;
    g.fg  = hue[ink];
    g.bg  = (paper >= 0 && !c.dots[paper][DOT_FIELD_W-1]) ? hue[paper] : fill;
    for (int k = 0; k < CELL_DOTS; k++)
      g.glyph[k] = same_dot(c, k, ink);
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic cell_t make_cell(input int col, input int row,
                                      input logic [DOT_FIELD_W-1:0] d0, d1, d2,
                                      input logic [DOT_FIELD_W-1:0] d3, d4, d5);
    cell_t c;
    c.col = COORD_W'(col);
    c.row = COORD_W'(row);
    c.dots = {d5, d4, d3, d2, d1, d0};
    return c;
  endfunction

  // Draw dots from a small palette so that repeats and ties are common.
  function automatic cell_t random_cell();
    cell_t   c;
    colour_t palette[4];
    int      hues;
    int      unset_pct;
    c.col = COORD_W'($urandom_range(0, 255));
    c.row = COORD_W'($urandom_range(0, 255));
    hues = $urandom_range(1, 4);
    unset_pct = ($urandom_range(0, 99) < 5) ? 100 : 10 * $urandom_range(0, 3);
    for (int p = 0; p < 4; p++)
      palette[p] = colour_t'($urandom_range(0, 255));
    for (int k = 0; k < CELL_DOTS; k++) begin
      if ($urandom_range(0, 99) < unset_pct)
        // Half of the unset dots are -1, the rest any negative value.
        c.dots[k] = $urandom_range(0, 1) ? UNSET : {1'b1, 8'($urandom_range(0, 255))};
      else
        c.dots[k] = {1'b0, palette[$urandom_range(0, hues - 1)]};
    end
    return c;
  endfunction

  // Wait until nothing is queued, offered or expected, then let the pipe settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cells.size() != 0 || in_tvalid || expected_glyphs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the empty paper register; the block is idle here.
  task automatic set_empty_paper(input colour_t value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    empty_fill = value;
    fill_settings++;
  endtask

  task automatic queue_random(input int count, input bit calm);
    @(negedge clk);
    no_gaps = calm;
    repeat (count) pending_cells.push_back(random_cell());
    wait_drained();
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at glyph beat %0d: %s", glyphs_checked, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  task automatic check_glyph(input logic [OUT_TDATA_W-1:0] data);
    glyph_beat_t want;
    if (expected_glyphs.size() == 0) begin
      report_mismatch($sformatf("unexpected beat 0x%0h", data));
    end else begin
      want = expected_glyphs.pop_front();
      check_field("out_col",    int'(data[7:0]),   int'(want.col));
      check_field("out_row",    int'(data[15:8]),  int'(want.row));
      check_field("fg_colour",  int'(data[23:16]), int'(want.fg));
      check_field("bg_colour",  int'(data[31:24]), int'(want.bg));
      check_field("glyph_bits", int'(data[37:32]), int'(want.glyph));
    end
    glyphs_checked++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer queued cells, hold each until accepted, predict on accept
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        // Beat taken: predict with the register value in force right now.
        cells_sent++;
        if (reduce_cell(held_cell, empty_fill, predicted))
          expected_glyphs.push_back(predicted);
        else
          cells_dropped++;
        offering = 1'b0;
      end else begin
        offering = in_tvalid;
      end
      // Advance to the next cell unless the sender idles this cycle.
      if (!offering && pending_cells.size() != 0 &&
          (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
        held_cell = pending_cells.pop_front();
        offering = 1'b1;
        in_tdata <= IN_TDATA_W'({held_cell.dots, held_cell.row, held_cell.col});
      end
      in_tvalid <= offering;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each glyph beat, drive out_tready with random stalls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        check_glyph(out_tdata);
      // Once, hold off long enough for both pipeline registers to fill
      // and for in_tready to drop while the sender keeps offering.
      if (!sink_hold_done && glyphs_checked >= HOLD_AFTER) begin
        sink_hold_done = 1'b1;
        sink_hold_left = HOLD_CYCLES;
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_gaps || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // Watchdog: give up when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no beat for %0d cycles, %0d glyphs outstanding",
                   quiet_cycles, expected_glyphs.size());
          $display("FAIL sextant_cell_two_colour_reducer");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed cells at the reset value of the empty paper register.
    @(negedge clk);
    // Every dot unset, as -1 and as other negative values: no glyph.
    pending_cells.push_back(make_cell(0, 0, UNSET, UNSET, UNSET, UNSET, UNSET, UNSET));
    pending_cells.push_back(make_cell(255, 255, 9'h100, 9'h1AB, 9'h1FF, 9'h180,
                                      9'h101, 9'h1FE));
    // Whole cell one colour: no paper, extremes of colour and position.
    pending_cells.push_back(make_cell(0, 255, 9'h000, 9'h000, 9'h000, 9'h000,
                                      9'h000, 9'h000));
    pending_cells.push_back(make_cell(255, 0, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
                                      9'h0FF, 9'h0FF));
    // Paper lands on an unset dot, at equal and at higher count than the ink.
    pending_cells.push_back(make_cell(1, 2, 9'h005, UNSET, 9'h005, UNSET, 9'h005, UNSET));
    pending_cells.push_back(make_cell(3, 4, UNSET, UNSET, 9'h009, UNSET, 9'h009, 9'h100));
    // Three-way tie: larger colour is ink, first highest-count dot is paper.
    pending_cells.push_back(make_cell(5, 6, 9'h007, 9'h007, 9'h0C8, 9'h0C8,
                                      9'h003, 9'h003));
    // Single set dot in the last position.
    pending_cells.push_back(make_cell(7, 8, UNSET, UNSET, UNSET, UNSET, UNSET, 9'h0AA));
    // Six distinct colours.
    pending_cells.push_back(make_cell(9, 10, 9'h000, 9'h001, 9'h002, 9'h003,
                                      9'h004, 9'h005));
    // Unset dots whose low bits look like the ink colour stay unset.
    pending_cells.push_back(make_cell(11, 12, 9'h105, 9'h005, 9'h005, 9'h105,
                                      9'h1FF, 9'h006));
    pending_cells.push_back(make_cell(13, 14, 9'h0FF, 9'h000, 9'h0FF, 9'h000,
                                      9'h000, 9'h0FF));
    pending_cells.push_back(make_cell(15, 16, 9'h001, 9'h002, 9'h002, 9'h003,
                                      9'h003, UNSET));
    pending_cells.push_back(make_cell(128, 127, 9'h0FF, 9'h080, 9'h07F, 9'h001,
                                      9'h000, 9'h055));
    pending_cells.push_back(make_cell(85, 170, 9'h0AA, UNSET, 9'h0AA, 9'h0AA,
                                      9'h0AA, 9'h0AA));
    wait_drained();

    // Random phases, each under its own empty paper colour. The sink
    // hold-off falls in the first; the third runs with no idling at all.
    set_empty_paper(8'hFF);
    queue_random(PHASE_CELLS, 1'b0);
    set_empty_paper(8'h00);
    queue_random(PHASE_CELLS, 1'b0);
    set_empty_paper(8'h5A);
    queue_random(PHASE_CELLS, 1'b1);
    set_empty_paper(colour_t'($urandom_range(0, 255)));
    queue_random(PHASE_CELLS, 1'b0);

    $display("Run covered %0d cells (%0d all unset, no glyph) and %0d glyph beats",
             cells_sent, cells_dropped, glyphs_checked);
    $display("under %0d empty paper settings; %0d mismatches", fill_settings + 1,
             mismatches);
    if (mismatches == 0)
      $display("PASS sextant_cell_two_colour_reducer");
    else
      $display("FAIL sextant_cell_two_colour_reducer");
    $finish;
  end

endmodule

### files.f
rtl/scr_pkg.sv
rtl/scr_reduce.sv
rtl/sextant_cell_two_colour_reducer.sv
tb/sextant_cell_two_colour_reducer_test.sv
